// ----- rtl/core/sfp8_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfp8_pkg
// Shared constants and types of the sync frame parser with Fletcher-8 check.
// ----------------------------------------------------------------------------
package sfp8_pkg;

  localparam logic [7:0]  SyncFirst   = 8'hB5;
  localparam logic [7:0]  SyncSecond  = 8'h62;
  localparam logic [15:0] MaxLenReset = 16'd256;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PAYLOAD = 3'd1,
    EV_GOOD    = 3'd2,
    EV_BAD_A   = 3'd3,
    EV_BAD_B   = 3'd4,
    EV_LONG    = 3'd5,
    EV_SYNC    = 3'd6
  } evt_e;

  typedef struct packed {
    logic [31:0] error_total;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [15:0] msg_len;
    logic [7:0]  msg_id;
    logic [7:0]  frame_class;
    evt_e        event_res;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/core/sfp8_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sfp8_parser
// Frame parser state machine with running Fletcher-8 sums and error count.
// ----------------------------------------------------------------------------
module sfp8_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic [15:0]       max_len_i,
  output sfp8_pkg::result_t      res_o
);

  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN_LO  = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CK_A    = 4'd7,
    PH_CK_B    = 4'd8
  } phase_e;

  phase_e        phase_q, phase_d;
  logic [7:0]    class_q, class_d;
  logic [7:0]    id_q, id_d;
  logic [15:0]   len_q, len_d;
  logic [15:0]   idx_q, idx_d;
  logic [7:0]    sum_a_q, sum_a_d;
  logic [7:0]    sum_b_q, sum_b_d;
  logic [31:0]   err_q, err_d;
  sfp8_pkg::evt_e evt;
  logic [15:0]   pidx;
  logic [7:0]    pbyte;
  logic [7:0]    sum_a_add, sum_b_add;
  logic [15:0]   len_full, idx_inc;
  logic [31:0]   err_inc;

  always_comb begin
    phase_d   = phase_q;
    class_d   = class_q;
    id_d      = id_q;
    len_d     = len_q;
    idx_d     = idx_q;
    sum_a_d   = sum_a_q;
    sum_b_d   = sum_b_q;
    err_d     = err_q;
    evt       = sfp8_pkg::EV_NONE;
    pidx      = '0;
    pbyte     = '0;
    sum_a_add = sum_a_q + rx_byte_i;
    sum_b_add = sum_b_q + sum_a_add;
    len_full  = {rx_byte_i, len_q[7:0]};
    idx_inc   = idx_q + 16'd1;
    err_inc   = err_q + 32'd1;
    unique case (phase_q)
      PH_SYNC2: begin
        sum_a_d = '0;
        sum_b_d = '0;
        if (rx_byte_i == sfp8_pkg::SyncSecond) begin
          phase_d = PH_CLASS;
        end else begin
          evt     = sfp8_pkg::EV_SYNC;
          phase_d = PH_SYNC1;
          idx_d   = '0;
        end
      end
      PH_CLASS: begin
        class_d = rx_byte_i;
        sum_a_d = sum_a_add;
        sum_b_d = sum_b_add;
        phase_d = PH_ID;
      end
      PH_ID: begin
        id_d    = rx_byte_i;
        sum_a_d = sum_a_add;
        sum_b_d = sum_b_add;
        phase_d = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_d   = {8'd0, rx_byte_i};
        sum_a_d = sum_a_add;
        sum_b_d = sum_b_add;
        phase_d = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_d   = len_full;
        sum_a_d = sum_a_add;
        sum_b_d = sum_b_add;
        if (len_full == 16'd0) begin
          phase_d = PH_CK_A;
        end else if (len_full > max_len_i) begin
          evt     = sfp8_pkg::EV_LONG;
          err_d   = err_inc;
          phase_d = PH_SYNC1;
          sum_a_d = '0;
          sum_b_d = '0;
          idx_d   = '0;
        end else begin
          idx_d   = '0;
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        evt     = sfp8_pkg::EV_PAYLOAD;
        pidx    = idx_q;
        pbyte   = rx_byte_i;
        sum_a_d = sum_a_add;
        sum_b_d = sum_b_add;
        idx_d   = idx_inc;
        if (idx_inc >= len_q || idx_inc == 16'd0) begin
          phase_d = PH_CK_A;
        end
      end
      PH_CK_A: begin
        if (rx_byte_i == sum_a_q) begin
          phase_d = PH_CK_B;
        end else begin
          evt     = sfp8_pkg::EV_BAD_A;
          err_d   = err_inc;
          phase_d = PH_SYNC1;
          sum_a_d = '0;
          sum_b_d = '0;
          idx_d   = '0;
        end
      end
      PH_CK_B: begin
        if (rx_byte_i == sum_b_q) begin
          evt   = sfp8_pkg::EV_GOOD;
        end else begin
          evt   = sfp8_pkg::EV_BAD_B;
          err_d = err_inc;
        end
        phase_d = PH_SYNC1;
        sum_a_d = '0;
        sum_b_d = '0;
        idx_d   = '0;
      end
      default: begin
        phase_d = (rx_byte_i == sfp8_pkg::SyncFirst) ? PH_SYNC2 : PH_SYNC1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SYNC1;
      class_q <= '0;
      id_q    <= '0;
      len_q   <= '0;
      idx_q   <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
      err_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      class_q <= class_d;
      id_q    <= id_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      err_q   <= err_d;
    end
  end

  always_comb begin
    res_o.event_res     = evt;
    res_o.frame_class   = class_d;
    res_o.msg_id        = id_d;
    res_o.msg_len       = len_d;
    res_o.payload_index = pidx;
    res_o.payload_byte  = pbyte;
    res_o.error_total   = err_d;
  end

endmodule
`default_nettype wire

// ----- rtl/core/sync_frame_parser_fletcher8.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sync_frame_parser_fletcher8
// Byte-serial sync frame parser with Fletcher-8 check and error counter.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one received byte per word. Each accepted byte
//   yields exactly one result word on the master stream: an event code in
//   tuser and the header fields, payload byte with its index and the running
//   error count in tdata. Payload bytes pass through unbuffered; commit
//   them downstream on the frame good event.
//   tvalid is high on the master side in the cycle after an accept; one byte
//   is accepted every cycle while the result queue has room.
//   A two-word result queue parts the two sides: s_axis_tready drops only
//   when both entries hold results that the receiver has not taken, so a
//   receiver stall costs one extra word of slack before input stalls.
//   The cfg channel writes max_len at any time it is valid; write it only
//   while no result is outstanding.
//   Reset clears the parser to hunting for the first sync byte, the sums,
//   header fields and error count to zero, max_len to 256, and empties the
//   result queue.
// ----------------------------------------------------------------------------
module sync_frame_parser_fletcher8 (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_wvalid_i,
  output      logic        cfg_wready_o,
  input  wire logic [15:0] cfg_wdata_i,     // max_len
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,  // rx_byte
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // frame_class, msg_id, msg_len, payload_index, payload_byte, error_total
  output      logic [87:0] m_axis_tdata_o,
  output      logic [2:0]  m_axis_tuser_o   // event_res
);

  logic              push, pop;
  logic [15:0]       max_len_q;
  sfp8_pkg::result_t res;
  sfp8_pkg::result_t buf_q [2];
  logic              wr_q, rd_q;
  logic [1:0]        cnt_q;

  assign cfg_wready_o    = 1'b1;
  assign s_axis_tready_o = (cnt_q != 2'd2);
  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign pop             = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= sfp8_pkg::MaxLenReset;
    end else if (cfg_wvalid_i && cfg_wready_o) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  sfp8_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (push),
    .rx_byte_i (s_axis_tdata_i),
    .max_len_i (max_len_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= res;
    end
  end

  assign m_axis_tuser_o = buf_q[rd_q].event_res;
  assign m_axis_tdata_o = {buf_q[rd_q].error_total,
                           buf_q[rd_q].payload_byte,
                           buf_q[rd_q].payload_index,
                           buf_q[rd_q].msg_len,
                           buf_q[rd_q].msg_id,
                           buf_q[rd_q].frame_class};

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result queue count out of range");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> m_axis_tvalid_o)
    else $error("accepted word produced no result");

  a_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != sfp8_pkg::EV_PAYLOAD)
      |-> (m_axis_tdata_o[55:32] == 24'd0))
    else $error("payload fields set on a non-payload event");
`endif

endmodule
`default_nettype wire

// ----- sim/tb_sync_frame_parser_fletcher8.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_sync_frame_parser_fletcher8
// Streams frames and noise into the parser and checks every result word
// against an in-bench parser model: event code, header fields, passed
// payload byte with its index and the error count. Runs directed frames,
// both ends of max_len, one payload past the reset limit and random traffic
// under several sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module tb_sync_frame_parser_fletcher8;

  localparam int unsigned RunLimit = 4_000_000;

  typedef enum logic [3:0] {
    P_SYNC1, P_SYNC2, P_CLASS, P_ID, P_LEN_LO, P_LEN_HI, P_PAYLOAD, P_CK_A, P_CK_B
  } phase_e;

  typedef enum logic [2:0] {
    K_GOOD, K_BAD_SYNC, K_BAD_A, K_BAD_B, K_LONG, K_NOISE
  } frame_kind_e;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_wvalid_i    = 1'b0;
  logic        cfg_wready_o;
  logic [15:0] cfg_wdata_i     = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [87:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;

  phase_e      phase_r   = P_SYNC1;
  logic [7:0]  cls_r     = '0;
  logic [7:0]  id_r      = '0;
  logic [15:0] len_r     = '0;
  logic [15:0] idx_r     = '0;
  logic [7:0]  sum_a_r   = '0;
  logic [7:0]  sum_b_r   = '0;
  logic [31:0] err_r     = '0;
  logic [15:0] max_len_r = sfp8_pkg::MaxLenReset;

  sfp8_pkg::result_t parser_out_q[$];
  int unsigned sent_count    = 0;
  int unsigned fail_count    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  sync_frame_parser_fletcher8 u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_wvalid_i    (cfg_wvalid_i),
    .cfg_wready_o    (cfg_wready_o),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic void restart_parse();
    phase_r = P_SYNC1;
    sum_a_r = '0;
    sum_b_r = '0;
    idx_r   = '0;
  endfunction

  function automatic void fold_sum(input logic [7:0] b);
    sum_a_r = sum_a_r + b;
    sum_b_r = sum_b_r + sum_a_r;
  endfunction

  function automatic sfp8_pkg::result_t predict_byte(input logic [7:0] b);
    sfp8_pkg::result_t r;
    r = '0;
    r.event_res = sfp8_pkg::EV_NONE;
    case (phase_r)
      P_SYNC2: begin
        if (b == sfp8_pkg::SyncSecond) begin
          phase_r = P_CLASS;
          sum_a_r = '0;
          sum_b_r = '0;
        end else begin
          r.event_res = sfp8_pkg::EV_SYNC;
          restart_parse();
        end
      end
      P_CLASS: begin
        cls_r = b;
        fold_sum(b);
        phase_r = P_ID;
      end
      P_ID: begin
        id_r = b;
        fold_sum(b);
        phase_r = P_LEN_LO;
      end
      P_LEN_LO: begin
        len_r = {8'h00, b};
        fold_sum(b);
        phase_r = P_LEN_HI;
      end
      P_LEN_HI: begin
        len_r[15:8] = b;
        fold_sum(b);
        if (len_r == 16'd0) begin
          phase_r = P_CK_A;
        end else if (len_r > max_len_r) begin
          r.event_res = sfp8_pkg::EV_LONG;
          err_r = err_r + 32'd1;
          restart_parse();
        end else begin
          idx_r   = '0;
          phase_r = P_PAYLOAD;
        end
      end
      P_PAYLOAD: begin
        r.event_res     = sfp8_pkg::EV_PAYLOAD;
        r.payload_index = idx_r;
        r.payload_byte  = b;
        fold_sum(b);
        idx_r = idx_r + 16'd1;
        if (idx_r >= len_r || idx_r == 16'd0) phase_r = P_CK_A;
      end
      P_CK_A: begin
        if (b == sum_a_r) begin
          phase_r = P_CK_B;
        end else begin
          r.event_res = sfp8_pkg::EV_BAD_A;
          err_r = err_r + 32'd1;
          restart_parse();
        end
      end
      P_CK_B: begin
        if (b == sum_b_r) begin
          r.event_res = sfp8_pkg::EV_GOOD;
        end else begin
          r.event_res = sfp8_pkg::EV_BAD_B;
          err_r = err_r + 32'd1;
        end
        restart_parse();
      end
      default: begin
        phase_r = (b == sfp8_pkg::SyncFirst) ? P_SYNC2 : P_SYNC1;
      end
    endcase
    r.frame_class = cls_r;
    r.msg_id      = id_r;
    r.msg_len     = len_r;
    r.error_total = err_r;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    sfp8_pkg::result_t got;
    sfp8_pkg::result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = sfp8_pkg::result_t'({m_axis_tdata_o, m_axis_tuser_o});
      if (parser_out_q.size() == 0) begin
        report_mismatch("unexpected word, event", 32'(got.event_res), 32'd0);
      end else begin
        want = parser_out_q.pop_front();
        if (got.event_res !== want.event_res)
          report_mismatch("event", 32'(got.event_res), 32'(want.event_res));
        if (got.frame_class !== want.frame_class)
          report_mismatch("frame_class", 32'(got.frame_class), 32'(want.frame_class));
        if (got.msg_id !== want.msg_id)
          report_mismatch("msg_id", 32'(got.msg_id), 32'(want.msg_id));
        if (got.msg_len !== want.msg_len)
          report_mismatch("msg_len", 32'(got.msg_len), 32'(want.msg_len));
        if (got.payload_index !== want.payload_index)
          report_mismatch("payload_index", 32'(got.payload_index),
                          32'(want.payload_index));
        if (got.payload_byte !== want.payload_byte)
          report_mismatch("payload_byte", 32'(got.payload_byte),
                          32'(want.payload_byte));
        if (got.error_total !== want.error_total)
          report_mismatch("error_total", got.error_total, want.error_total);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    parser_out_q.push_back(predict_byte(b));
    sent_count++;
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (parser_out_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_max_len(input logic [15:0] value);
    drain();
    cfg_wvalid_i <= 1'b1;
    cfg_wdata_i  <= value;
    do @(posedge clk_i); while (!cfg_wready_o);
    max_len_r = value;
    cfg_wvalid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_frame(input frame_kind_e kind, input logic [7:0] cls,
                            input logic [7:0] mid, input logic [15:0] len);
    logic [7:0] ck_a;
    logic [7:0] ck_b;
    logic [7:0] pl;
    int unsigned n;
    ck_a = '0;
    ck_b = '0;
    if (kind == K_NOISE) begin
      n = $urandom_range(1, 4);
      repeat (n) send_byte(8'($urandom));
    end else if (kind == K_BAD_SYNC) begin
      send_byte(sfp8_pkg::SyncFirst);
      pl = 8'($urandom);
      if (pl == sfp8_pkg::SyncSecond) pl = ~pl;
      send_byte(pl);
    end else begin
      send_byte(sfp8_pkg::SyncFirst);
      send_byte(sfp8_pkg::SyncSecond);
      send_byte(cls);
      ck_a = ck_a + cls;  ck_b = ck_b + ck_a;
      send_byte(mid);
      ck_a = ck_a + mid;  ck_b = ck_b + ck_a;
      send_byte(len[7:0]);
      ck_a = ck_a + len[7:0];  ck_b = ck_b + ck_a;
      send_byte(len[15:8]);
      ck_a = ck_a + len[15:8];  ck_b = ck_b + ck_a;
      if (kind != K_LONG) begin
        for (n = 0; n < len; n++) begin
          pl = 8'($urandom);
          send_byte(pl);
          ck_a = ck_a + pl;  ck_b = ck_b + ck_a;
        end
        if (kind == K_BAD_A) begin
          send_byte(ck_a ^ 8'($urandom_range(1, 255)));
        end else begin
          send_byte(ck_a);
          if (kind == K_BAD_B) send_byte(ck_b ^ 8'($urandom_range(1, 255)));
          else send_byte(ck_b);
        end
      end
    end
  endtask

  task automatic run_random(input int unsigned idle_pct, input int unsigned stl_pct,
                            input logic [15:0] lim, input int unsigned n_items);
    int unsigned start;
    int unsigned pick;
    logic [15:0] cap;
    logic [15:0] len;
    set_max_len(lim);
    send_idle_pct = idle_pct;
    stall_pct     = stl_pct;
    start         = sent_count;
    while (sent_count - start < n_items) begin
      pick = $urandom_range(0, 99);
      cap  = (lim < 16'd12) ? lim : 16'd12;
      if ($urandom_range(0, 19) == 0) cap = (lim < 16'd300) ? lim : 16'd300;
      len = 16'($urandom_range(0, cap));
      if (pick < 60)
        send_frame(K_GOOD, 8'($urandom), 8'($urandom), len);
      else if (pick < 68)
        send_frame(K_BAD_SYNC, 8'h00, 8'h00, 16'd0);
      else if (pick < 76)
        send_frame(K_BAD_A, 8'($urandom), 8'($urandom), len);
      else if (pick < 84)
        send_frame(K_BAD_B, 8'($urandom), 8'($urandom), len);
      else if (pick < 92 && lim != 16'hFFFF)
        send_frame(K_LONG, 8'($urandom), 8'($urandom),
                   16'($urandom_range(32'(lim) + 1, 32'hFFFF)));
      else
        send_frame(K_NOISE, 8'h00, 8'h00, 16'd0);
    end
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_frame(K_GOOD, 8'h00, 8'hFF, 16'd0);
    send_frame(K_BAD_SYNC, 8'h00, 8'h00, 16'd0);
    send_byte(sfp8_pkg::SyncFirst);
    send_byte(sfp8_pkg::SyncFirst);
    send_frame(K_BAD_B, 8'hFF, 8'h00, 16'd1);
    send_frame(K_LONG, 8'h5A, 8'hA5, 16'd257);
  endtask

  task automatic test_max_len_limits();
    set_max_len(16'd0);
    send_frame(K_GOOD, 8'h01, 8'h02, 16'd0);
    send_frame(K_LONG, 8'h03, 8'h04, 16'd1);
    send_frame(K_BAD_A, 8'h05, 8'h06, 16'd0);
    set_max_len(16'hFFFF);
    send_frame(K_GOOD, 8'h0A, 8'h0B, 16'd280);
  endtask

  task automatic test_no_idle();
    run_random(0, 0, 16'd300, 140);
    run_random(0, 0, 16'd0, 40);
  endtask

  task automatic test_sender_idle();
    run_random(74, 0, 16'd8, 120);
  endtask

  task automatic test_receiver_stall();
    run_random(0, 74, 16'hFFFF, 120);
  endtask

  task automatic test_both_idle();
    run_random(15, 15, 16'($urandom_range(1, 40)), 120);
  endtask

  initial begin
    int unsigned waited;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_max_len_limits();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    s_axis_tvalid_i <= 1'b0;
    waited = 0;
    while (parser_out_q.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    if (parser_out_q.size() != 0)
      report_mismatch("missing words", 32'(parser_out_q.size()), 32'd0);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(RunLimit);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
